>>> sv/sgbk_pkg.sv
// Shared types and constants of the stable group-by-key permuter.
package sgbk_pkg;

    localparam int KEY_W   = 16;
    localparam int POS_W   = 5;
    localparam int GRP_W   = 4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } in_beat_t;

    typedef struct packed {
        logic             pass_kind;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] mapped_index;
        logic [GRP_W-1:0] group_index;
        logic [POS_W-1:0] group_start;
        logic             overflow;
        logic             last_result;
    } out_beat_t;

    localparam logic PASS_SORTED = 1'b0;
    localparam logic PASS_ORIG   = 1'b1;

endpackage

>>> sv/stable_group_by_key_permuter.sv
// Top level of the stable group-by-key permuter.
// Items are loaded one a cycle: the key is matched in parallel against a row of group
// cells, each holding one group's key and size; a miss opens the next free cell. Each
// stored item records its group and its rank within the group. On the item marked last
// the block turns to emission: pass 0 walks groups and, within each, all stored items,
// one item slot per cycle while the output accepts beats, skipping none; pass 1 walks
// the items, one per cycle on the same condition. Each cell also keeps its group's start:
// set to the item count when the group opens and bumped by one whenever a lower-numbered
// group takes a beat, so the starts are ready as soon as loading ends. Emission holds off
// new input until the final beat of pass 1 has been taken. A last beat with nothing
// stored gives no results.
module stable_group_by_key_permuter #(
    parameter int MAX_ITEMS  = 32,
    parameter int MAX_GROUPS = 16,
    parameter int KEY_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sgbk_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sgbk_pkg::out_beat_t  out_data
);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int GC_W  = $clog2(MAX_GROUPS + 1);
    localparam int GI_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_PASS0 = 3'b010,
        ST_PASS1 = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_BITS-1:0]  key_m;
    logic [MAX_GROUPS-1:0] hit, open_v, join_v, grow_v;
    logic [CNT_W-1:0]     sizes  [MAX_GROUPS];
    logic [CNT_W-1:0]     starts [MAX_GROUPS];
    logic                 clear;

    logic [GI_W-1:0]  item_group_reg [MAX_ITEMS];
    logic [CNT_W-1:0] item_rank_reg  [MAX_ITEMS];
    logic [CNT_W-1:0] item_count_reg;
    logic [GC_W-1:0]  group_count_reg;
    logic             ovf_reg;
    logic [GI_W-1:0]  gw_reg;   // pass 0 group walker
    logic [IDX_W-1:0] iw_reg;   // item walker
    logic             obusy_reg;
    sgbk_pkg::out_beat_t out_data_reg;
    logic             do_load, any_hit, can_store, can_open;
    logic [GI_W-1:0]  hit_idx;
    logic [CNT_W-1:0] hit_size;
    logic             ovf_new;
    logic             emit_ok;
    sgbk_pkg::out_beat_t beat;
    logic             beat_v;
    logic             last_item, last_group, step;

    // Compare only the low KEY_BITS of the key.
    always_comb
    begin
        key_m = '0;
        for (int b = 0; b < KEY_BITS; b++)
        begin
            if (b < sgbk_pkg::KEY_W)
            begin
                key_m[b] = in_data.key[b];
            end
        end
    end

    genvar gg;
    generate
        for (gg = 0; gg < MAX_GROUPS; gg++)
        begin : g_cell
            sgbk_group_cell #(.KEY_BITS(KEY_BITS), .CNT_W(CNT_W)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .clear    (clear),
                .open_en  (open_v[gg]),
                .join_en  (join_v[gg]),
                .grow_en  (grow_v[gg]),
                .key      (key_m),
                .base     (item_count_reg),
                .hit      (hit[gg]),
                .size     (sizes[gg]),
                .start    (starts[gg])
            );
        end
    endgenerate

    assign in_ready = (state_reg == ST_LOAD) && !obusy_reg;
    assign do_load  = in_valid && in_ready;

    always_comb
    begin
        logic grow_run;
        any_hit  = |hit;
        hit_idx  = '0;
        hit_size = '0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            if (hit[g])
            begin
                hit_idx  = GI_W'(g);
                hit_size = sizes[g];
            end
        end
        can_store = item_count_reg < CNT_W'(MAX_ITEMS);
        can_open  = group_count_reg < GC_W'(MAX_GROUPS);
        open_v = '0;
        join_v = '0;
        if (do_load && can_store)
        begin
            for (int g = 0; g < MAX_GROUPS; g++)
            begin
                join_v[g] = hit[g];
                open_v[g] = !any_hit && can_open && (group_count_reg == GC_W'(g));
            end
        end
        // a joined group pushes every later group's start along by one
        grow_run = 1'b0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            grow_v[g] = grow_run;
            grow_run  = grow_run | join_v[g];
        end
        ovf_new = do_load && (!can_store || (!any_hit && !can_open));
    end

    // Output skid register.
    assign emit_ok = !obusy_reg || out_ready;

    always_comb
    begin
        logic [GI_W-1:0] ig;
        ig = item_group_reg[iw_reg];
        beat   = '0;
        beat_v = 1'b0;
        beat.overflow = ovf_reg;
        if (state_reg == ST_PASS0)
        begin
            beat_v = (ig == gw_reg);
            beat.pass_kind    = sgbk_pkg::PASS_SORTED;
            beat.position     = sgbk_pkg::POS_W'(starts[gw_reg] + item_rank_reg[iw_reg]);
            beat.mapped_index = sgbk_pkg::POS_W'(iw_reg);
            beat.group_index  = sgbk_pkg::GRP_W'(gw_reg);
            beat.group_start  = sgbk_pkg::POS_W'(starts[gw_reg]);
        end
        else if (state_reg == ST_PASS1)
        begin
            beat_v = 1'b1;
            beat.pass_kind    = sgbk_pkg::PASS_ORIG;
            beat.position     = sgbk_pkg::POS_W'(iw_reg);
            beat.mapped_index = sgbk_pkg::POS_W'(starts[ig] + item_rank_reg[iw_reg]);
            beat.group_index  = sgbk_pkg::GRP_W'(ig);
            beat.group_start  = sgbk_pkg::POS_W'(starts[ig]);
            beat.last_result  = (CNT_W'(iw_reg) + CNT_W'(1) == item_count_reg);
        end
    end

    assign step       = (state_reg != ST_LOAD) && emit_ok;
    assign last_item  = (CNT_W'(iw_reg) + CNT_W'(1) >= item_count_reg);
    assign last_group = (GC_W'(gw_reg) + GC_W'(1) >= group_count_reg);
    assign clear      = step && (state_reg == ST_PASS1) && last_item;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (do_load && in_data.last)
                begin
                    if ((can_store && (any_hit || can_open)) || item_count_reg != '0)
                    begin
                        state_next = ST_PASS0;
                    end
                end
            end
            ST_PASS0:
            begin
                if (step && last_item && last_group)
                begin
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1:
            begin
                if (clear)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            item_count_reg  <= '0;
            group_count_reg <= '0;
            ovf_reg         <= 1'b0;
            gw_reg          <= '0;
            iw_reg          <= '0;
            obusy_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_ok)
            begin
                obusy_reg <= step && beat_v;
            end
            if (do_load)
            begin
                if (ovf_new)
                begin
                    ovf_reg <= 1'b1;
                end
                if (|open_v || |join_v)
                begin
                    item_count_reg <= item_count_reg + CNT_W'(1);
                end
                if (|open_v)
                begin
                    group_count_reg <= group_count_reg + GC_W'(1);
                end
                if (in_data.last && state_next == ST_LOAD)
                begin
                    item_count_reg  <= '0;
                    group_count_reg <= '0;
                    ovf_reg         <= 1'b0;
                end
                gw_reg <= '0;
                iw_reg <= '0;
            end
            if (step)
            begin
                if (last_item)
                begin
                    iw_reg <= '0;
                    if (state_reg == ST_PASS0)
                    begin
                        gw_reg <= gw_reg + GI_W'(1);
                    end
                end
                else
                begin
                    iw_reg <= iw_reg + IDX_W'(1);
                end
            end
            if (clear)
            begin
                item_count_reg  <= '0;
                group_count_reg <= '0;
                ovf_reg         <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load && (|open_v || |join_v))
        begin
            item_group_reg[item_count_reg[IDX_W-1:0]] <= any_hit ? hit_idx
                                                                 : group_count_reg[GI_W-1:0];
            item_rank_reg[item_count_reg[IDX_W-1:0]]  <= any_hit ? hit_size : '0;
        end
        if (emit_ok && step && beat_v)
        begin
            out_data_reg <= beat;
        end
    end

    assign out_valid = obusy_reg;
    assign out_data  = out_data_reg;
endmodule

>>> sv/sgbk_group_cell.sv
// One group cell: holds a group key, size and start offset, and matches keys.
module sgbk_group_cell #(
    parameter int KEY_BITS = 16,
    parameter int CNT_W    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                open_en,
    input  logic                join_en,
    input  logic                grow_en,
    input  logic [KEY_BITS-1:0] key,
    input  logic [CNT_W-1:0]    base,
    output logic                hit,
    output logic [CNT_W-1:0]    size,
    output logic [CNT_W-1:0]    start
);
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [CNT_W-1:0]    start_reg;
    logic                active_reg;

    // start: item count at open, then one more for each beat a lower group takes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= '0;
            start_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (clear)
        begin
            size_reg   <= '0;
            start_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (open_en)
        begin
            size_reg   <= CNT_W'(1);
            start_reg  <= base;
            active_reg <= 1'b1;
        end
        else
        begin
            if (join_en)
            begin
                size_reg <= size_reg + CNT_W'(1);
            end
            if (grow_en)
            begin
                start_reg <= start_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (open_en)
        begin
            key_reg <= key;
        end
    end

    assign hit   = active_reg && (key_reg == key);
    assign size  = size_reg;
    assign start = start_reg;
endmodule
